// ===== rtl/ipv4hc_pkg.sv =====
// shared types and constants for the ipv4 header length and checksum inserter
`default_nettype none
package ipv4hc_pkg;

  localparam int HDR_BYTES   = 20;
  localparam int HDR_AW      = $clog2(HDR_BYTES);
  localparam int POS_W       = $clog2(HDR_BYTES + 1);
  localparam int SUM_W       = 20;
  localparam int LEN_POS     = 2;
  localparam int CSUM_POS    = 10;
  localparam int QUEUE_DEPTH_DEF = 4;

  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [HDR_AW-1:0] hdr_addr_t;

  localparam pos_t POS_FIRST   = '0;
  localparam pos_t POS_HDR_END = POS_W'(HDR_BYTES - 1);
  localparam pos_t POS_PAYLOAD = POS_W'(HDR_BYTES);

  typedef enum logic [1:0] {
    CMD_DATA = 2'd0,
    CMD_HDR  = 2'd1,
    CMD_ERR  = 2'd2
  } cmd_kind_t;

  // one queue entry: a passthrough byte, a header burst or an oversize error
  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  data;
    logic        last;
    logic [15:0] total_len;
    logic [15:0] csum;
  } cmd_t;

  typedef struct packed {
    logic      en;
    hdr_addr_t addr;
    logic [7:0] data;
  } hdr_wr_t;

endpackage
`default_nettype wire

// ===== rtl/ipv4hc_intf.sv =====
// valid/ready channel interfaces for packet bytes in and out
`default_nettype none
interface ipv4hc_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  in_byte;
  logic [15:0] payload_length;
  logic        in_last;

  modport source (output valid, output in_byte, output payload_length, output in_last,
                  input ready);
  modport sink (input valid, input in_byte, input payload_length, input in_last,
                output ready);
endinterface

interface ipv4hc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;
  logic       status;

  modport source (output valid, output out_byte, output out_last, output status,
                  input ready);
  modport sink (input valid, input out_byte, input out_last, input status,
                output ready);
endinterface
`default_nettype wire

// ===== rtl/ipv4_header_build_checksum.sv =====
// top level: ipv4 header total length and checksum insertion on a byte stream
// path: a payload byte passes through the queue register and then the output register; the
//   first header byte takes the same path after the transfer of the last header byte
// throughput: payload 1 byte per cycle unless the queue is full or the output stalls;
//   a 20-byte header is played out from the header buffer, and the next header waits for that
// reset: rst_n synchronous, active low, clears control state; header buffer keeps contents
`default_nettype none
module ipv4_header_build_checksum #(
  parameter int QUEUE_DEPTH = ipv4hc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  ipv4hc_in_if.sink     in_ch,
  ipv4hc_out_if.source  out_ch
);
  import ipv4hc_pkg::*;

  logic      q_push;
  cmd_t      q_cmd;
  logic      q_pop;
  cmd_t      q_head;
  logic      q_full;
  logic      q_empty;
  hdr_wr_t   hdr_wr;
  hdr_addr_t rd_addr;
  logic [7:0] rd_data;
  logic      hdr_done;

  ipv4hc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .q_full   (q_full),
    .hdr_done (hdr_done),
    .q_push   (q_push),
    .q_cmd    (q_cmd),
    .hdr_wr   (hdr_wr)
  );

  ipv4hc_hdr_buf #(
    .WIDTH (8),
    .DEPTH (HDR_BYTES)
  ) u_hdr_buf (
    .clk     (clk),
    .wr_en   (hdr_wr.en),
    .wr_addr (hdr_wr.addr),
    .wr_data (hdr_wr.data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  ipv4hc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .pop      (q_pop),
    .head     (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  ipv4hc_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_head   (q_head),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .hdr_done (hdr_done),
    .out_ch   (out_ch)
  );

endmodule
`default_nettype wire

// ===== rtl/ipv4hc_hdr_buf.sv =====
// generic ram: one write port and one registered read port
`default_nettype none
module ipv4hc_hdr_buf #(
  parameter int WIDTH = 8,
  parameter int DEPTH = ipv4hc_pkg::HDR_BYTES
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// ===== rtl/ipv4hc_queue.sv =====
// short command queue between the front and the back
`default_nettype none
module ipv4hc_queue #(
  parameter int DEPTH = ipv4hc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  ipv4hc_pkg::cmd_t push_cmd,
  input  logic             pop,
  output ipv4hc_pkg::cmd_t head,
  output logic             full,
  output logic             empty
);
  import ipv4hc_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  cmd_t          mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == CNT_FULL);
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + AW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + AW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full) else $error("queue push while full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty) else $error("queue pop while empty");

endmodule
`default_nettype wire

// ===== rtl/ipv4hc_front.sv =====
// front: takes bytes, buffers the header, sums it and queues commands for the back
`default_nettype none
module ipv4hc_front (
  input  logic                clk,
  input  logic                rst_n,
  ipv4hc_in_if.sink           in_ch,
  input  logic                q_full,
  input  logic                hdr_done,
  output logic                q_push,
  output ipv4hc_pkg::cmd_t    q_cmd,
  output ipv4hc_pkg::hdr_wr_t hdr_wr
);
  import ipv4hc_pkg::*;

  pos_t              pos_r, pos_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [15:0]       tot_r, tot_nxt;
  logic              drop_r, drop_nxt;
  logic              busy_r, busy_nxt;

  logic              hdr_phase;
  logic              acc;
  logic [16:0]       tot_full;
  logic [SUM_W-1:0]  sum_base;
  logic [SUM_W-1:0]  term;
  logic [SUM_W-1:0]  sum_add;
  logic              excluded;
  logic [16:0]       fold1;
  logic [15:0]       fold2;

  assign hdr_phase   = !drop_r && (pos_r != POS_PAYLOAD);
  // header bytes wait while the back still reads the previous header
  assign in_ch.ready = !q_full && !(hdr_phase && busy_r);
  assign acc         = in_ch.valid && in_ch.ready;

  assign tot_full = {1'b0, in_ch.payload_length} + 17'(HDR_BYTES);
  assign excluded = (pos_r == POS_W'(LEN_POS))  || (pos_r == POS_W'(LEN_POS + 1)) ||
                    (pos_r == POS_W'(CSUM_POS)) || (pos_r == POS_W'(CSUM_POS + 1));
  assign sum_base = (pos_r == POS_FIRST) ? SUM_W'(tot_full) : sum_r;
  assign term     = pos_r[0] ? SUM_W'(in_ch.in_byte) : SUM_W'({in_ch.in_byte, 8'h00});
  assign sum_add  = excluded ? sum_base : sum_base + term;

  // end-around carry fold, twice
  assign fold1 = {1'b0, sum_add[15:0]} + 17'(sum_add[SUM_W-1:16]);
  assign fold2 = fold1[15:0] + 16'(fold1[16]);

  always_comb begin
    pos_nxt  = pos_r;
    sum_nxt  = sum_r;
    tot_nxt  = tot_r;
    drop_nxt = drop_r;
    busy_nxt = busy_r;
    q_push   = 1'b0;
    q_cmd    = '{kind: CMD_DATA, data: in_ch.in_byte, last: in_ch.in_last,
                 total_len: tot_r, csum: ~fold2};
    hdr_wr   = '{en: 1'b0, addr: pos_r[HDR_AW-1:0], data: in_ch.in_byte};
    if (hdr_done) begin
      busy_nxt = 1'b0;
    end
    if (acc) begin
      priority if (drop_r) begin
        if (in_ch.in_last) begin
          drop_nxt = 1'b0;
          pos_nxt  = POS_FIRST;
          sum_nxt  = '0;
        end
      end else if (pos_r == POS_PAYLOAD) begin
        q_push = 1'b1;
        if (in_ch.in_last) begin
          pos_nxt = POS_FIRST;
          sum_nxt = '0;
        end
      end else if ((pos_r == POS_FIRST) && tot_full[16]) begin
        q_push     = 1'b1;
        q_cmd.kind = CMD_ERR;
        drop_nxt   = !in_ch.in_last;
        tot_nxt    = tot_full[15:0];
        sum_nxt    = '0;
      end else begin
        hdr_wr.en = 1'b1;
        sum_nxt   = sum_add;
        if (pos_r == POS_FIRST) begin
          tot_nxt         = tot_full[15:0];
          q_cmd.total_len = tot_full[15:0];
        end
        if (pos_r == POS_HDR_END) begin
          q_push     = 1'b1;
          q_cmd.kind = CMD_HDR;
          busy_nxt   = 1'b1;
          pos_nxt    = in_ch.in_last ? POS_FIRST : POS_PAYLOAD;
          sum_nxt    = '0;
        end else if (in_ch.in_last) begin
          pos_nxt = POS_FIRST;
          sum_nxt = '0;
        end else begin
          pos_nxt = pos_r + POS_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= POS_FIRST;
      sum_r  <= '0;
      tot_r  <= '0;
      drop_r <= 1'b0;
      busy_r <= 1'b0;
    end else begin
      pos_r  <= pos_nxt;
      sum_r  <= sum_nxt;
      tot_r  <= tot_nxt;
      drop_r <= drop_nxt;
      busy_r <= busy_nxt;
    end
  end

  a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    hdr_wr.en |-> !busy_r) else $error("header written while back reads it");
  a_hdr_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && q_cmd.kind == CMD_HDR) |-> (pos_r == POS_HDR_END))
    else $error("header burst queued before full header");

endmodule
`default_nettype wire

// ===== rtl/ipv4hc_back.sv =====
// back: plays out queued commands into the output register
`default_nettype none
module ipv4hc_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ipv4hc_pkg::cmd_t      q_head,
  input  logic                  q_empty,
  output logic                  q_pop,
  output ipv4hc_pkg::hdr_addr_t rd_addr,
  input  logic [7:0]            rd_data,
  output logic                  hdr_done,
  ipv4hc_out_if.source          out_ch
);
  import ipv4hc_pkg::*;

  localparam hdr_addr_t ADDR_LAST = HDR_AW'(HDR_BYTES - 1);

  hdr_addr_t  cnt_r, cnt_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r, out_byte_nxt;
  logic       out_last_r, out_last_nxt;
  logic       out_status_r, out_status_nxt;
  logic       slot_free;
  logic [7:0] hdr_byte;

  assign slot_free = !out_valid_r || out_ch.ready;
  // buffer read is registered, so fetch the byte for the next cycle
  assign rd_addr   = cnt_nxt;

  // length and checksum fields replace the buffered bytes
  always_comb begin
    priority if (cnt_r == HDR_AW'(LEN_POS)) begin
      hdr_byte = q_head.total_len[15:8];
    end else if (cnt_r == HDR_AW'(LEN_POS + 1)) begin
      hdr_byte = q_head.total_len[7:0];
    end else if (cnt_r == HDR_AW'(CSUM_POS)) begin
      hdr_byte = q_head.csum[15:8];
    end else if (cnt_r == HDR_AW'(CSUM_POS + 1)) begin
      hdr_byte = q_head.csum[7:0];
    end else begin
      hdr_byte = rd_data;
    end
  end

  always_comb begin
    cnt_nxt        = cnt_r;
    out_valid_nxt  = out_valid_r;
    out_byte_nxt   = out_byte_r;
    out_last_nxt   = out_last_r;
    out_status_nxt = out_status_r;
    q_pop          = 1'b0;
    hdr_done       = 1'b0;
    if (slot_free && !q_empty) begin
      out_valid_nxt = 1'b1;
      unique case (q_head.kind)
        CMD_DATA: begin
          out_byte_nxt   = q_head.data;
          out_last_nxt   = q_head.last;
          out_status_nxt = 1'b0;
          q_pop          = 1'b1;
        end
        CMD_ERR: begin
          out_byte_nxt   = 8'h00;
          out_last_nxt   = 1'b1;
          out_status_nxt = 1'b1;
          q_pop          = 1'b1;
        end
        CMD_HDR: begin
          out_byte_nxt   = hdr_byte;
          out_last_nxt   = q_head.last && (cnt_r == ADDR_LAST);
          out_status_nxt = 1'b0;
          if (cnt_r == ADDR_LAST) begin
            cnt_nxt  = '0;
            q_pop    = 1'b1;
            hdr_done = 1'b1;
          end else begin
            cnt_nxt = cnt_r + HDR_AW'(1);
          end
        end
        default: begin
          out_valid_nxt = 1'b0;
          q_pop         = 1'b1;
        end
      endcase
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r   <= out_byte_nxt;
    out_last_r   <= out_last_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_byte = out_byte_r;
  assign out_ch.out_last = out_last_r;
  assign out_ch.status   = out_status_r;

  a_done_on_hdr: assert property (@(posedge clk) disable iff (!rst_n)
    hdr_done |-> (q_pop && q_head.kind == CMD_HDR)) else $error("burst end without header");
  a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r) |-> (out_last_r && out_byte_r == 8'h00))
    else $error("error result not a lone final result");

endmodule
`default_nettype wire
